### design/thermal_raw_to_celsius_top_assert.svh
// Assertion macros used by the thermal converter checker.
`ifndef THERMAL_RAW_TO_CELSIUS_TOP_ASSERT_SVH
`define THERMAL_RAW_TO_CELSIUS_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during rst.
`define TRC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trc assertion failed");

// Next-cycle implication, clocked on clk, off during rst.
`define TRC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trc assertion failed");

`endif

### design/trc_pkg.sv
// Shared constants and widths of the thermal raw-to-Celsius converter.
package trc_pkg;

  localparam int FRAME_ROWS = 120;
  localparam int FRAME_COLS = 160;
  localparam int COUNT_MAX  = 32767;
  localparam int FRAME_CAP  = (FRAME_ROWS * FRAME_COLS > COUNT_MAX) ?
                              COUNT_MAX : FRAME_ROWS * FRAME_COLS;

  localparam int KELVIN_ZERO_Q6 = 17482;
  localparam int CEL_MAX        = 131071;
  localparam int CEL_MIN        = -17482;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  localparam int MUL_W     = 32;
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [2:0] {
    CFG_RAW_OFFSET    = 3'd0,
    CFG_INVERSE_GAIN  = 3'd1,
    CFG_PLANCK_OFFSET = 3'd2,
    CFG_PLANCK_R      = 3'd3,
    CFG_PLANCK_F      = 3'd4,
    CFG_PLANCK_B      = 3'd5
  } cfg_index_t;

endpackage

### design/trc_mul.sv
// Shared unsigned multiplier with a registered product.
module trc_mul (
  input  logic                          clk,
  input  logic [trc_pkg::MUL_W-1:0]     a,
  input  logic [trc_pkg::MUL_W-1:0]     b,
  output logic [2*trc_pkg::MUL_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### design/trc_div.sv
// Shared restoring divider, one quotient bit per cycle.
module trc_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [trc_pkg::DIV_NUM_W-1:0]   dividend,
  input  logic [trc_pkg::DIV_DEN_W-1:0]   divisor,
  output logic                            done,
  output logic [trc_pkg::DIV_NUM_W-1:0]   quotient
);

  logic                            busy;
  logic [trc_pkg::DIV_CNT_W-1:0]   cnt;
  logic [trc_pkg::DIV_DEN_W-1:0]   rem;
  logic [trc_pkg::DIV_DEN_W-1:0]   den;
  logic [trc_pkg::DIV_DEN_W:0]     trial;
  logic [trc_pkg::DIV_DEN_W:0]     diff;
  logic                            ge;

  always_comb begin
    trial = {rem, quotient[trc_pkg::DIV_NUM_W-1]};
    diff  = trial - {1'b0, den};
    ge    = trial >= {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        quotient <= {quotient[trc_pkg::DIV_NUM_W-2:0], ge};
        rem      <= ge ? diff[trc_pkg::DIV_DEN_W-1:0] : trial[trc_pkg::DIV_DEN_W-1:0];
        cnt      <= cnt + 1'b1;
        if (cnt == trc_pkg::DIV_CNT_W'(trc_pkg::DIV_NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/thermal_raw_to_celsius_top.sv
// Thermal raw-to-Celsius converter: offset, gain, inverse Planck law, frame mean.
// Each pixel takes up to two divides (a third for the mean on a frame's last pixel),
// a normalize shift loop and 16 squarings.
// One pixel in flight; s_axis_tready is high only while idle.
// Synchronous reset restores register defaults and clears frame sum and count.
// The result register holds a finished result while the next pixel is taken.
module thermal_raw_to_celsius_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] raw_sample
  input  logic        s_axis_tlast,   // last_pixel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [17:0] pixel_celsius, [35:18] frame_mean, zero pad
  output logic        m_axis_tuser,   // pixel_invalid
  output logic        m_axis_tlast    // mean_valid
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_OBJ_M, ST_OBJ, ST_QDIV, ST_NORM, ST_SQ_M, ST_SQ,
    ST_LOG, ST_LN_M, ST_LN, ST_KDIV, ST_ACC, ST_MDIV, ST_FIN
  } state_t;

  state_t state;

  logic signed [24:0] raw_offset;
  logic [19:0]        inverse_gain;
  logic signed [24:0] planck_offset;
  logic [31:0]        planck_r_ratio;
  logic [19:0]        planck_f;
  logic [19:0]        planck_b;

  logic signed [35:0] temperature_sum;
  logic [14:0]        pixel_count;

  logic [trc_pkg::MUL_W-1:0]       mul_a;
  logic [trc_pkg::MUL_W-1:0]       mul_b;
  logic [2*trc_pkg::MUL_W-1:0]     mul_p;
  logic                            div_start;
  logic [trc_pkg::DIV_NUM_W-1:0]   div_num;
  logic [trc_pkg::DIV_DEN_W-1:0]   div_den;
  logic                            div_done;
  logic [trc_pkg::DIV_NUM_W-1:0]   div_q;

  logic               last_q;
  logic               sign_neg;
  logic [48:0]        nrm;
  logic [5:0]         pexp;
  logic [3:0]         iter;
  logic [15:0]        frac;
  logic signed [17:0] cel_r;
  logic               inv_r;
  logic [17:0]        mean_r;
  logic signed [17:0] out_cel;
  logic [17:0]        out_mean;

  // datapath terms
  logic signed [26:0] diff;
  logic [26:0]        diff_mag;
  logic [46:0]        obj_sum;
  logic signed [32:0] obj;
  logic signed [32:0] den;
  logic [32:0]        den_mag;
  logic signed [49:0] arg;
  logic [30:0]        sq_m;
  logic signed [6:0]  int_part;
  logic signed [22:0] log2v;
  logic [22:0]        log_mag;
  logic [52:0]        ln_sum;
  logic [22:0]        ln_mag;
  logic signed [35:0] kval;
  logic signed [35:0] cel_full;
  logic               take;
  logic signed [35:0] sum_upd;
  logic [14:0]        cnt_upd;
  logic [35:0]        sum_mag;

  trc_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  trc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    diff     = $signed({3'b000, s_axis_tdata, 8'h00}) - {{2{raw_offset[24]}}, raw_offset};
    diff_mag = diff[26] ? 27'(-diff) : 27'(diff);
    obj_sum  = mul_p[46:0] + 47'h8000;
    obj      = sign_neg ? -$signed({2'b00, obj_sum[46:16]}) : $signed({2'b00, obj_sum[46:16]});
    den      = obj + {{8{planck_offset[24]}}, planck_offset};
    den_mag  = den[32] ? 33'(-den) : 33'(den);
    arg      = sign_neg ? $signed({30'b0, planck_f}) - $signed({2'b00, div_q})
                        : $signed({30'b0, planck_f}) + $signed({2'b00, div_q});
    sq_m     = mul_p[61] ? mul_p[61:31] : mul_p[60:30];
    int_part = $signed({1'b0, pexp}) - 7'sd16;
    log2v    = {int_part, frac};
    log_mag  = log2v[22] ? 23'(-log2v) : 23'(log2v);
    ln_sum   = mul_p[52:0] + 53'h2000_0000;
    ln_mag   = ln_sum[52:30];
    kval     = sign_neg ? -$signed({1'b0, div_q[34:0]}) : $signed({1'b0, div_q[34:0]});
    cel_full = kval - 36'(trc_pkg::KELVIN_ZERO_Q6);
    take     = pixel_count < 15'(trc_pkg::FRAME_CAP);
    sum_upd  = take ? temperature_sum + 36'(cel_r) : temperature_sum;
    cnt_upd  = take ? pixel_count + 15'd1 : pixel_count;
    sum_mag  = sum_upd[35] ? 36'(-sum_upd) : 36'(sum_upd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      raw_offset      <= '0;
      inverse_gain    <= 20'd65536;
      planck_offset   <= '0;
      planck_r_ratio  <= '0;
      planck_f        <= 20'd65536;
      planck_b        <= '0;
      temperature_sum <= '0;
      pixel_count     <= '0;
      m_axis_tvalid   <= 1'b0;
      div_start       <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          trc_pkg::CFG_RAW_OFFSET:    raw_offset     <= $signed(cfg_data[24:0]);
          trc_pkg::CFG_INVERSE_GAIN:  inverse_gain   <= cfg_data[19:0];
          trc_pkg::CFG_PLANCK_OFFSET: planck_offset  <= $signed(cfg_data[24:0]);
          trc_pkg::CFG_PLANCK_R:      planck_r_ratio <= cfg_data;
          trc_pkg::CFG_PLANCK_F:      planck_f       <= cfg_data[19:0];
          trc_pkg::CFG_PLANCK_B:      planck_b       <= cfg_data[19:0];
          default: ;
        endcase
      end
      // ST_FIN reloads the result register itself
      if (m_axis_tvalid && m_axis_tready && state != ST_FIN) m_axis_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            last_q   <= s_axis_tlast;
            sign_neg <= diff[26];
            mul_a    <= {5'b0, diff_mag};
            mul_b    <= {12'b0, inverse_gain};
            inv_r    <= 1'b0;
            mean_r   <= '0;
            state    <= ST_OBJ_M;
          end
        end
        ST_OBJ_M: state <= ST_OBJ;
        ST_OBJ: begin
          if (den == '0) begin
            inv_r <= 1'b1;
            cel_r <= 18'(trc_pkg::CEL_MAX);
            state <= ST_ACC;
          end else begin
            sign_neg  <= den[32];
            div_num   <= {planck_r_ratio, 16'h0000};
            div_den   <= den_mag[31:0];
            div_start <= 1'b1;
            state     <= ST_QDIV;
          end
        end
        ST_QDIV: begin
          if (div_done) begin
            if (arg[49] || arg == '0) begin
              inv_r <= 1'b1;
              cel_r <= 18'(trc_pkg::CEL_MAX);
              state <= ST_ACC;
            end else begin
              nrm   <= arg[48:0];
              pexp  <= 6'd48;
              state <= ST_NORM;
            end
          end
        end
        ST_NORM: begin
          // shift until the leading one reaches the top bit
          if (nrm[48]) begin
            mul_a <= {1'b0, nrm[48:18]};
            mul_b <= {1'b0, nrm[48:18]};
            iter  <= '0;
            frac  <= '0;
            state <= ST_SQ_M;
          end else begin
            nrm  <= {nrm[47:0], 1'b0};
            pexp <= pexp - 6'd1;
          end
        end
        ST_SQ_M: state <= ST_SQ;
        ST_SQ: begin
          frac[4'd15 - iter] <= mul_p[61];
          mul_a <= {1'b0, sq_m};
          mul_b <= {1'b0, sq_m};
          iter  <= iter + 4'd1;
          state <= (iter == 4'd15) ? ST_LOG : ST_SQ_M;
        end
        ST_LOG: begin
          sign_neg <= log2v[22];
          mul_a    <= {9'b0, log_mag};
          mul_b    <= {2'b00, trc_pkg::LN2_Q30};
          state    <= ST_LN_M;
        end
        ST_LN_M: state <= ST_LN;
        ST_LN: begin
          if (ln_mag == '0) begin
            inv_r <= 1'b1;
            cel_r <= 18'(trc_pkg::CEL_MAX);
            state <= ST_ACC;
          end else begin
            div_num   <= {14'b0, planck_b, 14'b0} + {26'b0, ln_mag[22:1]};
            div_den   <= {9'b0, ln_mag};
            div_start <= 1'b1;
            state     <= ST_KDIV;
          end
        end
        ST_KDIV: begin
          if (div_done) begin
            priority if (cel_full < 36'(trc_pkg::CEL_MIN)) cel_r <= 18'(trc_pkg::CEL_MIN);
            else if (cel_full > 36'(trc_pkg::CEL_MAX))     cel_r <= 18'(trc_pkg::CEL_MAX);
            else                                           cel_r <= cel_full[17:0];
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (last_q) begin
            temperature_sum <= '0;
            pixel_count     <= '0;
            if (cnt_upd != '0) begin
              sign_neg  <= sum_upd[35];
              div_num   <= {12'b0, sum_mag} + {34'b0, cnt_upd[14:1]};
              div_den   <= {17'b0, cnt_upd};
              div_start <= 1'b1;
              state     <= ST_MDIV;
            end else begin
              state <= ST_FIN;
            end
          end else begin
            temperature_sum <= sum_upd;
            pixel_count     <= cnt_upd;
            state           <= ST_FIN;
          end
        end
        ST_MDIV: begin
          if (div_done) begin
            mean_r <= sign_neg ? 18'(-div_q[17:0]) : div_q[17:0];
            state  <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold until the result register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            out_cel       <= cel_r;
            out_mean      <= mean_r;
            m_axis_tuser  <= inv_r;
            m_axis_tlast  <= last_q;
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {4'b0000, out_mean, out_cel};

endmodule

### design/trc_checker.sv
// Port-level checker for the thermal converter, bound to the top level.
`include "thermal_raw_to_celsius_top_assert.svh"

module trc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  `TRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `TRC_ASSERT_NEXT(a_busy_after_request, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `TRC_ASSERT_NOW(a_invalid_saturates, m_axis_tvalid && m_axis_tuser,
                  m_axis_tdata[17:0] == 18'h1FFFF)
  `TRC_ASSERT_NOW(a_mean_zero_midframe, m_axis_tvalid && !m_axis_tlast,
                  m_axis_tdata[35:18] == 18'h00000)

endmodule

bind thermal_raw_to_celsius_top trc_checker u_trc_checker (.*);
